>>> design/potts_pkg.sv
package potts_pkg;

    // Fixed field widths of the item and result words, and the largest number of states.
    localparam int SPIN_W    = 3;
    localparam int ROWIN_W   = 5;
    localparam int OP_W      = 2;
    localparam int Q_W       = 4;
    localparam int DE_W      = 4;
    localparam int CNT_W     = 3;
    localparam int PROB_BITS = 16;
    localparam int MAX_STATES = 8;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    // Operation codes carried in s_tuser.
    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_SPIN_STATES  = 3'd0;
    localparam logic [2:0] REG_THRESH_ONE   = 3'd1;
    localparam logic [2:0] REG_THRESH_TWO   = 3'd2;
    localparam logic [2:0] REG_THRESH_THREE = 3'd3;
    localparam logic [2:0] REG_THRESH_FOUR  = 3'd4;

    // Register reset values.
    localparam logic [Q_W-1:0]       RST_SPIN_STATES  = 4'd2;
    localparam logic [PROB_BITS-1:0] RST_THRESH_ONE   = 16'd24109;
    localparam logic [PROB_BITS-1:0] RST_THRESH_TWO   = 16'd8869;
    localparam logic [PROB_BITS-1:0] RST_THRESH_THREE = 16'd3263;
    localparam logic [PROB_BITS-1:0] RST_THRESH_FOUR  = 16'd1200;

    // Control of the shared neighbor compare unit.
    typedef struct packed {
        logic clear;
        logic valid;
    } potts_cmp_ctl_t;

endpackage

>>> design/potts_grid_mem.sv
module potts_grid_mem
    import potts_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [SPIN_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [SPIN_W-1:0] rd_data
);

    logic [SPIN_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> design/potts_energy_unit.sv
module potts_energy_unit
    import potts_pkg::*;
(
    input  logic                   aclk,
    input  potts_cmp_ctl_t         ctl,
    input  logic [SPIN_W-1:0]      nbr_spin,
    input  logic [SPIN_W-1:0]      cur_spin,
    input  logic [SPIN_W-1:0]      prop_spin,
    output logic signed [DE_W-1:0] energy_change
);

    // One neighbor is compared per cycle in which ctl.valid is set, against the current and the proposed spin.
    logic [CNT_W-1:0] same_cur_reg, same_cur_next;
    logic [CNT_W-1:0] same_new_reg, same_new_next;

    always_comb begin
        same_cur_next = same_cur_reg;
        same_new_next = same_new_reg;
        if (ctl.clear) begin
            same_cur_next = '0;
            same_new_next = '0;
        end else if (ctl.valid) begin
            same_cur_next = same_cur_reg + CNT_W'(nbr_spin == cur_spin);
            same_new_next = same_new_reg + CNT_W'(nbr_spin == prop_spin);
        end
    end

    always_ff @(posedge aclk) begin
        same_cur_reg <= same_cur_next;
        same_new_reg <= same_new_next;
    end

    assign energy_change = $signed({1'b0, same_cur_reg}) - $signed({1'b0, same_new_reg});

endmodule

>>> design/potts_metropolis_site_update.sv
// Metropolis site update for a q-state Potts model held on a periodic GRID_SIDE x GRID_SIDE
// grid in an on-chip memory with one read and one write port. Each input word is a write,
// a read or one Metropolis step at the addressed site, and each gives exactly one result
// word; an unknown operation gives one flagged bad. After reset the block sweeps the grid
// to zero, one site a cycle, over all GRID_SIDE*GRID_SIDE sites (1024 at the default size);
// s_tready stays low during that sweep, while register writes are taken as usual. A word
// then passes S_RDC, S_CUR and S_FIN, a Metropolis step also S_NB1 to S_NB4 and S_DEC: the
// step reads the site and its four neighbors in turn through the single read port, and one
// shared compare unit counts the neighbors equal to the current and the proposed spin, one
// neighbor a cycle. A new word is taken while the last result waits in the output register.
module potts_metropolis_site_update
    import potts_pkg::*;
#(
    parameter int GRID_SIDE = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input channel.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata from bit 0: row[4:0], column[9:5], spin_value[12:10], first_pick[15:13],
    // shift_pick[18:16], accept_rand[34:19], zero fill up to bit 39.
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: operation[1:0].
    input  logic [OP_W-1:0]       s_tuser,
    // Result channel.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata from bit 0: spin_out[2:0], accepted[3], energy_change[7:4], bad_item[8],
    // zero fill up to bit 15.
    output logic [M_TDATA_W-1:0]  m_tdata,
    // Register port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    localparam int CELLS   = GRID_SIDE * GRID_SIDE;
    localparam int CELL_W  = $clog2(CELLS);
    localparam int COORD_W = $clog2(GRID_SIDE);
    localparam int ROW_VALS = 1 << ROWIN_W;

    // Sequencer states.
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RDC  = 4'd2;
    localparam logic [3:0] S_CUR  = 4'd3;
    localparam logic [3:0] S_NB1  = 4'd4;
    localparam logic [3:0] S_NB2  = 4'd5;
    localparam logic [3:0] S_NB3  = 4'd6;
    localparam logic [3:0] S_NB4  = 4'd7;
    localparam logic [3:0] S_DEC  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    // ------------------------------------------------------------------
    // Register file.
    // ------------------------------------------------------------------
    logic [Q_W-1:0]       spin_states_reg;
    logic [PROB_BITS-1:0] thr_one_reg, thr_two_reg, thr_three_reg, thr_four_reg;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spin_states_reg <= RST_SPIN_STATES;
            thr_one_reg     <= RST_THRESH_ONE;
            thr_two_reg     <= RST_THRESH_TWO;
            thr_three_reg   <= RST_THRESH_THREE;
            thr_four_reg    <= RST_THRESH_FOUR;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_SPIN_STATES:  spin_states_reg <= pwdata[Q_W-1:0];
                REG_THRESH_ONE:   thr_one_reg     <= pwdata[PROB_BITS-1:0];
                REG_THRESH_TWO:   thr_two_reg     <= pwdata[PROB_BITS-1:0];
                REG_THRESH_THREE: thr_three_reg   <= pwdata[PROB_BITS-1:0];
                REG_THRESH_FOUR:  thr_four_reg    <= pwdata[PROB_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_SPIN_STATES:  prdata = APB_DW'(spin_states_reg);
            REG_THRESH_ONE:   prdata = APB_DW'(thr_one_reg);
            REG_THRESH_TWO:   prdata = APB_DW'(thr_two_reg);
            REG_THRESH_THREE: prdata = APB_DW'(thr_three_reg);
            REG_THRESH_FOUR:  prdata = APB_DW'(thr_four_reg);
            default:          prdata = '0;
        endcase
    end

    // The number of states in use is clamped into 2..MAX_STATES.
    logic [Q_W-1:0] q_eff;
    always_comb begin
        if (spin_states_reg < Q_W'(2)) begin
            q_eff = Q_W'(2);
        end else if (spin_states_reg > Q_W'(MAX_STATES)) begin
            q_eff = Q_W'(MAX_STATES);
        end else begin
            q_eff = spin_states_reg;
        end
    end

    // ------------------------------------------------------------------
    // Coordinate reduction: row and column are taken modulo the grid side
    // through a small constant table built at elaboration.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] coord_tab [ROW_VALS];
    for (genvar gi = 0; gi < ROW_VALS; gi++) begin : g_coord
        assign coord_tab[gi] = COORD_W'(gi % GRID_SIDE);
    end

    // ------------------------------------------------------------------
    // Item registers.
    // ------------------------------------------------------------------
    logic [OP_W-1:0]      op_reg;
    logic [COORD_W-1:0]   row_reg, col_reg;
    logic [SPIN_W-1:0]    sval_reg, pick_reg, shift_reg;
    logic [PROB_BITS-1:0] rnd_reg;
    logic                 in_accept;

    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            op_reg    <= s_tuser;
            row_reg   <= coord_tab[s_tdata[4:0]];
            col_reg   <= coord_tab[s_tdata[9:5]];
            sval_reg  <= s_tdata[12:10];
            pick_reg  <= s_tdata[15:13];
            shift_reg <= s_tdata[18:16];
            rnd_reg   <= s_tdata[34:19];
        end
    end

    // Neighbor coordinates with periodic wrap.
    logic [COORD_W-1:0] row_up, row_dn, col_lf, col_rt;
    assign row_up = (row_reg == '0) ? COORD_W'(GRID_SIDE - 1) : row_reg - COORD_W'(1);
    assign row_dn = (row_reg == COORD_W'(GRID_SIDE - 1)) ? '0 : row_reg + COORD_W'(1);
    assign col_lf = (col_reg == '0) ? COORD_W'(GRID_SIDE - 1) : col_reg - COORD_W'(1);
    assign col_rt = (col_reg == COORD_W'(GRID_SIDE - 1)) ? '0 : col_reg + COORD_W'(1);

    function automatic logic [CELL_W-1:0] cell_addr(input logic [COORD_W-1:0] r,
                                                    input logic [COORD_W-1:0] c);
        return CELL_W'(CELL_W'(r) * CELL_W'(GRID_SIDE)) + CELL_W'(c);
    endfunction

    // ------------------------------------------------------------------
    // Sequencer and datapath.
    // ------------------------------------------------------------------
    logic [3:0]              state_reg, state_next;
    logic [CELL_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [SPIN_W-1:0]       cur_reg, cur_next;
    logic [SPIN_W-1:0]       prop_reg, prop_next;
    logic [SPIN_W-1:0]       res_spin_reg, res_spin_next;
    logic                    res_acc_reg, res_acc_next;
    logic signed [DE_W-1:0]  res_de_reg, res_de_next;
    logic                    res_bad_reg, res_bad_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [SPIN_W-1:0]       m_spin_reg, m_spin_next;
    logic                    m_acc_reg, m_acc_next;
    logic signed [DE_W-1:0]  m_de_reg, m_de_next;
    logic                    m_bad_reg, m_bad_next;

    logic                    mem_we;
    logic [CELL_W-1:0]       mem_waddr, mem_raddr;
    logic [SPIN_W-1:0]       mem_wdata, mem_rdata;
    potts_cmp_ctl_t          cmp_ctl;
    logic signed [DE_W-1:0]  de_w;

    // Proposal in the cycle where the current spin arrives from memory.
    logic [Q_W-1:0]       pick_sum, pick_mod;
    logic [SPIN_W-1:0]    prop_w;
    logic                 upd_bad;
    logic [PROB_BITS-1:0] thr_sel;
    logic                 flip_ok;

    assign pick_sum = Q_W'(pick_reg) + Q_W'(shift_reg);
    assign pick_mod = (pick_sum >= q_eff) ? pick_sum - q_eff : pick_sum;
    assign prop_w   = (pick_reg == mem_rdata) ? pick_mod[SPIN_W-1:0] : pick_reg;
    assign upd_bad  = (Q_W'(pick_reg) >= q_eff) ||
                      ((pick_reg == mem_rdata) &&
                       ((shift_reg == '0) || (Q_W'(shift_reg) >= q_eff)));

    always_comb begin
        case (de_w[2:0])
            3'd1:    thr_sel = thr_one_reg;
            3'd2:    thr_sel = thr_two_reg;
            3'd3:    thr_sel = thr_three_reg;
            default: thr_sel = thr_four_reg;
        endcase
    end

    assign flip_ok = de_w[DE_W-1] || (de_w == '0) || (thr_sel > rnd_reg);

    // Read address follows the state: center first, then up, down, left, right.
    always_comb begin
        case (state_reg)
            S_CUR:   mem_raddr = cell_addr(row_up, col_reg);
            S_NB1:   mem_raddr = cell_addr(row_dn, col_reg);
            S_NB2:   mem_raddr = cell_addr(row_reg, col_lf);
            S_NB3:   mem_raddr = cell_addr(row_reg, col_rt);
            default: mem_raddr = cell_addr(row_reg, col_reg);
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cur_next       = cur_reg;
        prop_next      = prop_reg;
        res_spin_next  = res_spin_reg;
        res_acc_next   = res_acc_reg;
        res_de_next    = res_de_reg;
        res_bad_next   = res_bad_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_spin_next    = m_spin_reg;
        m_acc_next     = m_acc_reg;
        m_de_next      = m_de_reg;
        m_bad_next     = m_bad_reg;
        mem_we         = 1'b0;
        mem_waddr      = cell_addr(row_reg, col_reg);
        mem_wdata      = '0;
        cmp_ctl.clear  = 1'b0;
        cmp_ctl.valid  = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_CLR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + CELL_W'(1);
                if (clr_cnt_reg == CELL_W'(CELLS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    state_next = S_RDC;
                end
            end
            S_RDC: begin
                state_next = S_CUR;
            end
            S_CUR: begin
                // The site's current spin is on the read data now.
                res_spin_next = mem_rdata;
                res_acc_next  = 1'b0;
                res_de_next   = '0;
                res_bad_next  = 1'b0;
                state_next    = S_FIN;
                case (op_reg)
                    OP_WRITE: begin
                        if (Q_W'(sval_reg) < q_eff) begin
                            mem_we        = 1'b1;
                            mem_wdata     = sval_reg;
                            res_spin_next = sval_reg;
                        end else begin
                            res_bad_next = 1'b1;
                        end
                    end
                    OP_UPDATE: begin
                        if (upd_bad) begin
                            res_bad_next = 1'b1;
                        end else begin
                            cur_next      = mem_rdata;
                            prop_next     = prop_w;
                            cmp_ctl.clear = 1'b1;
                            state_next    = S_NB1;
                        end
                    end
                    OP_READ: ;
                    default: res_bad_next = 1'b1;
                endcase
            end
            S_NB1: begin
                cmp_ctl.valid = 1'b1;
                state_next    = S_NB2;
            end
            S_NB2: begin
                cmp_ctl.valid = 1'b1;
                state_next    = S_NB3;
            end
            S_NB3: begin
                cmp_ctl.valid = 1'b1;
                state_next    = S_NB4;
            end
            S_NB4: begin
                cmp_ctl.valid = 1'b1;
                state_next    = S_DEC;
            end
            S_DEC: begin
                res_de_next = de_w;
                if (flip_ok) begin
                    mem_we        = 1'b1;
                    mem_wdata     = prop_reg;
                    res_spin_next = prop_reg;
                    res_acc_next  = 1'b1;
                end else begin
                    res_spin_next = cur_reg;
                end
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_spin_next   = res_spin_reg;
                    m_acc_next    = res_acc_reg;
                    m_de_next     = res_de_reg;
                    m_bad_next    = res_bad_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        prop_reg     <= prop_next;
        res_spin_reg <= res_spin_next;
        res_acc_reg  <= res_acc_next;
        res_de_reg   <= res_de_next;
        res_bad_reg  <= res_bad_next;
        m_spin_reg   <= m_spin_next;
        m_acc_reg    <= m_acc_next;
        m_de_reg     <= m_de_next;
        m_bad_reg    <= m_bad_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_bad_reg, m_de_reg, m_acc_reg, m_spin_reg};

    // ------------------------------------------------------------------
    // Grid memory and the shared neighbor compare unit.
    // ------------------------------------------------------------------
    potts_grid_mem #(
        .DEPTH  (CELLS),
        .ADDR_W (CELL_W)
    ) u_grid (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    potts_energy_unit u_energy (
        .aclk          (aclk),
        .ctl           (cmp_ctl),
        .nbr_spin      (mem_rdata),
        .cur_spin      (cur_reg),
        .prop_spin     (prop_reg),
        .energy_change (de_w)
    );

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again before the item finished");

    a_accept_not_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_acc_reg && m_bad_reg))
        else $error("result both accepted and flagged bad");

    a_de_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_de_reg <= 4'sd4) && (m_de_reg >= -4'sd4))
        else $error("energy change outside -4..4");

    a_bad_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_bad_reg) |-> (m_de_reg == '0) && !m_acc_reg)
        else $error("bad result carries update fields");

endmodule

>>> tb/potts_site_update_checker.sv
`timescale 1ns / 1ps

module potts_site_update_checker
    import potts_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // s_tdata from bit 0: row, column, spin_value, first_pick, shift_pick, accept_rand.
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: operation.
    input  logic [OP_W-1:0]      s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata from bit 0: spin_out, accepted, energy_change, bad_item.
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    input  logic                 pready,
    output int unsigned          mismatches,
    output int unsigned          words_pending
);

    localparam int GRID_CELLS = 1024;

    // Packed in the same order as m_tdata[8:0].
    typedef struct packed {
        logic                   bad_item;
        logic signed [DE_W-1:0] energy_change;
        logic                   accepted;
        logic [SPIN_W-1:0]      spin_out;
    } site_result_t;

    logic [SPIN_W-1:0]    spin_grid_copy [GRID_CELLS];
    logic [Q_W-1:0]       spin_states_copy;
    logic [PROB_BITS-1:0] thresh_copy [1:4];
    site_result_t         expected_sites [$];

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Applies one input word to the grid copy and returns the result word it gives.
    task automatic update_site(input logic [OP_W-1:0] op, input logic [S_TDATA_W-1:0] word,
                               output site_result_t res);
        logic [4:0]           row, col, row_up, row_dn, col_lf, col_rt;
        logic [SPIN_W-1:0]    sval, pick, shift, cur, prop;
        logic [PROB_BITS-1:0] rnd;
        logic [SPIN_W-1:0]    nbr [4];
        int                   q, same_cur, same_new, de;
        logic [9:0]           idx;
        row   = word[4:0];
        col   = word[9:5];
        sval  = word[12:10];
        pick  = word[15:13];
        shift = word[18:16];
        rnd   = word[34:19];
        idx   = {row, col};
        q     = (spin_states_copy < 2) ? 2 :
                (spin_states_copy > MAX_STATES) ? MAX_STATES : int'(spin_states_copy);
        res   = '0;
        de    = 0;
        case (op)
            OP_WRITE: begin
                if (sval < q) spin_grid_copy[idx] = sval;
                else res.bad_item = 1'b1;
            end
            OP_UPDATE: begin
                cur  = spin_grid_copy[idx];
                prop = pick;
                if (pick >= q) begin
                    res.bad_item = 1'b1;
                end else if (pick == cur && (shift < 1 || shift >= q)) begin
                    res.bad_item = 1'b1;
                end else begin
                    if (pick == cur) prop = SPIN_W'((int'(pick) + int'(shift)) % q);
                    // Five-bit arithmetic wraps at the grid edges.
                    row_up = row - 5'd1;
                    row_dn = row + 5'd1;
                    col_lf = col - 5'd1;
                    col_rt = col + 5'd1;
                    nbr[0] = spin_grid_copy[{row_up, col}];
                    nbr[1] = spin_grid_copy[{row_dn, col}];
                    nbr[2] = spin_grid_copy[{row, col_lf}];
                    nbr[3] = spin_grid_copy[{row, col_rt}];
                    same_cur = 0;
                    same_new = 0;
                    for (int k = 0; k < 4; k++) begin
                        if (nbr[k] == cur) same_cur++;
                        if (nbr[k] == prop) same_new++;
                    end
                    de = same_cur - same_new;
                    if (de <= 0 || thresh_copy[de] > rnd) begin
                        res.accepted = 1'b1;
                        spin_grid_copy[idx] = prop;
                    end
                end
            end
            OP_READ: begin
            end
            default: res.bad_item = 1'b1;
        endcase
        res.energy_change = DE_W'(de);
        res.spin_out      = spin_grid_copy[idx];
    endtask

    always @(posedge aclk) begin
        site_result_t want, got;
        if (!aresetn) begin
            for (int i = 0; i < GRID_CELLS; i++) spin_grid_copy[i] = '0;
            spin_states_copy = RST_SPIN_STATES;
            thresh_copy[1]   = RST_THRESH_ONE;
            thresh_copy[2]   = RST_THRESH_TWO;
            thresh_copy[3]   = RST_THRESH_THREE;
            thresh_copy[4]   = RST_THRESH_FOUR;
            expected_sites.delete();
            mismatches = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_AW-1:2])
                    REG_SPIN_STATES:  spin_states_copy = pwdata[Q_W-1:0];
                    REG_THRESH_ONE:   thresh_copy[1]   = pwdata[PROB_BITS-1:0];
                    REG_THRESH_TWO:   thresh_copy[2]   = pwdata[PROB_BITS-1:0];
                    REG_THRESH_THREE: thresh_copy[3]   = pwdata[PROB_BITS-1:0];
                    REG_THRESH_FOUR:  thresh_copy[4]   = pwdata[PROB_BITS-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[8:0];
                if (expected_sites.size() == 0) begin
                    report_mismatch($sformatf("result word 0x%h with nothing pending", m_tdata));
                end else begin
                    want = expected_sites.pop_front();
                    if (got.spin_out !== want.spin_out)
                        report_mismatch($sformatf("spin_out got %0d expected %0d",
                                                  got.spin_out, want.spin_out));
                    if (got.accepted !== want.accepted)
                        report_mismatch($sformatf("accepted got %0d expected %0d",
                                                  got.accepted, want.accepted));
                    if (got.energy_change !== want.energy_change)
                        report_mismatch($sformatf("energy_change got %0d expected %0d",
                                                  got.energy_change, want.energy_change));
                    if (got.bad_item !== want.bad_item)
                        report_mismatch($sformatf("bad_item got %0d expected %0d",
                                                  got.bad_item, want.bad_item));
                end
            end
            if (s_tvalid && s_tready) begin
                update_site(s_tuser, s_tdata, want);
                expected_sites.push_back(want);
            end
        end
        words_pending <= expected_sites.size();
    end

endmodule

>>> tb/potts_metropolis_site_update_tb.sv
`timescale 1ns / 1ps

// Top of the site update bench. It makes the clock and reset, programs the registers,
// drives input words and paces the result channel. All prediction and comparison sits
// in the checker instance, which hands back its mismatch count and the number of result
// words still owed by the block.
module potts_metropolis_site_update_tb
    import potts_pkg::*;
();

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 9;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 88;
    localparam int PRESSURE_PHASE  = 4;
    localparam int HOLD_CYCLES     = 300;
    localparam int TAIL_CYCLES     = 30;
    // Covers the clearing sweep after reset plus every word at its slowest pace, many times.
    localparam int CYCLE_LIMIT     = 500000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // s_tdata from bit 0: row[4:0], column[9:5], spin_value[12:10], first_pick[15:13],
    // shift_pick[18:16], accept_rand[34:19], zero fill up to bit 39.
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // s_tuser: operation[1:0].
    logic [OP_W-1:0]      s_tuser  = OP_READ;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // m_tdata from bit 0: spin_out[2:0], accepted[3], energy_change[7:4], bad_item[8],
    // zero fill up to bit 15.
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [APB_DW-1:0]    pwdata   = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    int unsigned mismatches;
    int unsigned words_pending;

    // Percent of cycles in which the sender holds back a word or the receiver stalls.
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_kick      = 1'b0;
    int   hold_left      = 0;
    int   cycle_count    = 0;

    potts_metropolis_site_update u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    potts_site_update_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .mismatches    (mismatches),
        .words_pending (words_pending)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // The run is cut off and reported failed when the cycle count reaches CYCLE_LIMIT.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("potts_metropolis_site_update_tb failed");
            $finish;
        end
    end

    // A long receiver hold-off, counted here so that the sender keeps pushing words
    // while the result register stays full and the block has to drop s_tready.
    always @(posedge aclk) begin
        if (hold_kick) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result side pacing: random stalls at the rate of the current phase.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // One register write: a setup phase, an access phase held until pready and an idle step
    // with psel low after it, so that back-to-back writes never drive psel twice in one step.
    task automatic apb_write(input logic [2:0] reg_idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({reg_idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [Q_W-1:0] states,
                                 input logic [PROB_BITS-1:0] t1, t2, t3, t4);
        apb_write(REG_SPIN_STATES, APB_DW'(states));
        apb_write(REG_THRESH_ONE, APB_DW'(t1));
        apb_write(REG_THRESH_TWO, APB_DW'(t2));
        apb_write(REG_THRESH_THREE, APB_DW'(t3));
        apb_write(REG_THRESH_FOUR, APB_DW'(t4));
    endtask

    // Offers one word and returns at the edge where it is taken. Idle gaps go in front
    // of the word, so a valid that stays high is never dropped within a step.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [4:0] row, col,
                             input logic [2:0] sval, pick, shift,
                             input logic [PROB_BITS-1:0] rnd);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, rnd, shift, pick, sval, col, row};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops offering and waits until every word sent so far has its result back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (words_pending != 0);
    endtask

    initial begin
        logic [Q_W-1:0]       phase_states [RANDOM_PHASES];
        logic [PROB_BITS-1:0] th [1:4];
        logic [OP_W-1:0]      op;
        logic [4:0]           row, col;
        logic [2:0]           sval, pick, shift;
        logic [PROB_BITS-1:0] rnd;
        int                   q_eff, k;

        // Out-of-range settings (0, 1 and 15) check the clamping of q.
        phase_states = '{4'd2, 4'd3, 4'd8, 4'd0, 4'd15, 4'd1, 4'd5, 4'd4};

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Register writes are taken during the clearing sweep; the first word waits
        // for s_tready on its own.
        apb_write(REG_SPIN_STATES, APB_DW'(4));

        // Directed words at q = 4 with the reset thresholds. Site (0,0) gets neighbors
        // across both wrapped edges.
        send_word(OP_READ,   5'd0,  5'd0,  3'd0, 3'd0, 3'd0, 16'h0000);
        send_word(OP_WRITE,  5'd0,  5'd0,  3'd3, 3'd0, 3'd0, 16'h0000);
        send_word(OP_WRITE,  5'd31, 5'd0,  3'd3, 3'd0, 3'd0, 16'h0000);
        send_word(OP_WRITE,  5'd0,  5'd31, 3'd2, 3'd0, 3'd0, 16'h0000);
        send_word(OP_WRITE,  5'd31, 5'd31, 3'd1, 3'd0, 3'd0, 16'h0000);
        // A spin value at or above q must leave the grid alone.
        send_word(OP_WRITE,  5'd2,  5'd2,  3'd7, 3'd0, 3'd0, 16'h0000);
        // Proposal equal to the current spin takes the shifted value.
        send_word(OP_UPDATE, 5'd0,  5'd0,  3'd0, 3'd3, 3'd1, 16'h0000);
        // A proposal out of range, then shifts of zero and of one at or above q when one is needed.
        send_word(OP_UPDATE, 5'd0,  5'd0,  3'd0, 3'd7, 3'd1, 16'h0000);
        send_word(OP_UPDATE, 5'd0,  5'd0,  3'd0, 3'd0, 3'd0, 16'h0000);
        send_word(OP_UPDATE, 5'd0,  5'd0,  3'd0, 3'd0, 3'd7, 16'h0000);
        // An unused shift of zero is fine; the same rise is rejected, then accepted.
        send_word(OP_UPDATE, 5'd0,  5'd0,  3'd0, 3'd2, 3'd0, 16'hFFFF);
        send_word(OP_UPDATE, 5'd0,  5'd0,  3'd0, 3'd2, 3'd0, 16'h0000);
        // All four neighbors equal: a rise of four, rejected and then accepted, and
        // the flip back gives a drop of four.
        send_word(OP_UPDATE, 5'd5,  5'd5,  3'd0, 3'd1, 3'd1, 16'hFFFF);
        send_word(OP_UPDATE, 5'd5,  5'd5,  3'd0, 3'd1, 3'd1, 16'h0000);
        send_word(OP_UPDATE, 5'd5,  5'd5,  3'd0, 3'd0, 3'd1, 16'hFFFF);
        // The unknown operation with every data bit set is flagged bad and only reads the site.
        send_word(OP_UNKNOWN, 5'd31, 5'd31, 3'd7, 3'd7, 3'd7, 16'hFFFF);
        send_word(OP_READ,   5'd31, 5'd31, 3'd0, 3'd0, 3'd0, 16'h0000);
        send_word(OP_READ,   5'd31, 5'd0,  3'd0, 3'd0, 3'd0, 16'h0000);
        wait_drained();

        // Lower q below a stored spin of 3: that spin never matches a proposal.
        apb_write(REG_SPIN_STATES, APB_DW'(2));
        send_word(OP_UPDATE, 5'd31, 5'd0,  3'd0, 3'd0, 3'd0, 16'h8000);
        send_word(OP_READ,   5'd31, 5'd0,  3'd0, 3'd0, 3'd0, 16'h0000);
        send_word(OP_UPDATE, 5'd31, 5'd0,  3'd0, 3'd1, 3'd7, 16'h0000);
        send_word(OP_WRITE,  5'd31, 5'd0,  3'd2, 3'd0, 3'd0, 16'h0000);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: th = '{RST_THRESH_ONE, RST_THRESH_TWO, RST_THRESH_THREE, RST_THRESH_FOUR};
                1: th = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                2: th = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
                7: th = '{16'd40000, 16'd20000, 16'd10000, 16'd5000};
                default: begin
                    for (int i = 1; i <= 4; i++) th[i] = PROB_BITS'($urandom_range(65535));
                end
            endcase
            load_settings(phase_states[phase], th[1], th[2], th[3], th[4]);
            q_eff = (phase_states[phase] < 2) ? 2 :
                    (phase_states[phase] > MAX_STATES) ? MAX_STATES : int'(phase_states[phase]);

            // Idling pattern of the phase: none, sender, receiver, both.
            case (phase % 4)
                1: begin
                    send_idle_pct  = 76;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 76;
                end
                3: begin
                    send_idle_pct  = 24;
                    recv_stall_pct <= 24;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 0;
                end
            endcase

            if (phase == PRESSURE_PHASE) begin
                hold_kick <= 1'b1;
                @(posedge aclk);
                hold_kick <= 1'b0;
            end

            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                // Most words land in a small window around the wrapped corner so that
                // neighbors interact; the rest roam the whole grid.
                if ($urandom_range(99) < 75) begin
                    row = 5'd30 + 5'($urandom_range(3));
                    col = 5'd30 + 5'($urandom_range(3));
                end else begin
                    row = 5'($urandom_range(31));
                    col = 5'($urandom_range(31));
                end
                if ($urandom_range(19) == 0) rnd = ($urandom_range(1) == 1) ? 16'hFFFF : 16'h0000;
                else rnd = PROB_BITS'($urandom_range(65535));
                sval  = 3'($urandom_range(q_eff - 1));
                pick  = 3'($urandom_range(q_eff - 1));
                shift = 3'($urandom_range(q_eff - 1, 1));
                k = $urandom_range(99);
                if (k < 20) begin
                    op = OP_WRITE;
                    if (k < 3) sval = 3'($urandom_range(7));
                end else if (k < 85) begin
                    // Mostly well-formed proposals, with a few broken picks and shifts.
                    op = OP_UPDATE;
                    if (k >= 80) pick = 3'($urandom_range(7));
                    if ($urandom_range(9) == 0) shift = 3'($urandom_range(7));
                end else if (k < 97) begin
                    op = OP_READ;
                    sval = 3'($urandom_range(7));
                end else begin
                    op = OP_UNKNOWN;
                    sval = 3'($urandom_range(7));
                    pick = 3'($urandom_range(7));
                    shift = 3'($urandom_range(7));
                end
                send_word(op, row, col, sval, pick, shift, rnd);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("potts_metropolis_site_update_tb passed");
        end else begin
            $display("potts_metropolis_site_update_tb failed");
        end
        $finish;
    end

endmodule
